/* hdl/tsr_pkg.sv */
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and a helper for the transport-stream SNDU reassembler
// Holds the result kind codes, the result struct and CRC helper.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int unsigned QDepth = 4;

  typedef enum logic [3:0] {
    K_PAYLOAD  = 4'd0,
    K_OK       = 4'd1,
    K_CRC_FAIL = 4'd2,
    K_BAD_CELL = 4'd3,
    K_DISCONT  = 4'd4,
    K_BAD_PTR  = 4'd5,
    K_BAD_LEN  = 4'd6,
    K_FLUSHED  = 4'd7,
    K_SHORT    = 4'd8
  } kind_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       kind;
    logic [15:0] sndu_type;
    logic        dest_absent;
    logic        last;
  } result_t;

  // MPEG-2 CRC-32, one byte, MSB first
  function automatic logic [31:0] crc_feed(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* hdl/tsr_parser.sv */
// ----------------------------------------------------------------------------
// tsr_parser: front end
// Checks cell headers, tracks continuity and pointer, parses SNDUs byte by
// byte and produces at most one result per input byte.
// ----------------------------------------------------------------------------
module tsr_parser import tsr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    cell_byte,
  input  logic          cell_start,
  output logic          res_valid,
  output result_t       res
);

  typedef enum logic [12:0] {
    PH_IDLE  = 13'b0000000000001,
    PH_HDR   = 13'b0000000000010,
    PH_HBAD  = 13'b0000000000100,
    PH_PTRS  = 13'b0000000001000,
    PH_PTRC  = 13'b0000000010000,
    PH_SKIP  = 13'b0000000100000,
    PH_LEN0  = 13'b0000001000000,
    PH_LEN1  = 13'b0000010000000,
    PH_NEXT0 = 13'b0000100000000,
    PH_NEXT1 = 13'b0001000000000,
    PH_TYPE0 = 13'b0010000000000,
    PH_TYPE1 = 13'b0100000000000,
    PH_DATA  = 13'b1000000000000
  } phase_t;

  logic        await_r, await_nxt;
  logic [3:0]  ecc_r, ecc_nxt;
  logic [7:0]  pos_r, pos_nxt;
  phase_t      ph_r, ph_nxt;
  logic        insndu_r, insndu_nxt;
  logic [14:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] type_r, type_nxt;
  logic        thalf_r, thalf_nxt;
  logic        dbit_r, dbit_nxt;
  logic [7:0]  ptr_r, ptr_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crx_r, crx_nxt;

  logic [7:0]  pos;
  logic [15:0] v;

  always_comb begin
    await_nxt = await_r; ecc_nxt = ecc_r; pos_nxt = pos_r; ph_nxt = ph_r;
    insndu_nxt = insndu_r; len_nxt = len_r; left_nxt = left_r; type_nxt = type_r;
    thalf_nxt = thalf_r; dbit_nxt = dbit_r; ptr_nxt = ptr_r; held_nxt = held_r;
    crc_nxt = crc_r; crx_nxt = crx_r;
    res_valid = 1'b0;
    res = '{out_byte: 8'd0, kind: K_PAYLOAD, sndu_type: type_r, dest_absent: dbit_r,
            last: 1'b0};
    pos = pos_r + 8'd1;
    v = {held_r, cell_byte};
    if (step) begin
      if (cell_start) begin
        if (!insndu_r && len_r == 15'd0) await_nxt = 1'b1;
        pos_nxt = 8'd0;
        ph_nxt = (cell_byte == 8'h47) ? PH_HDR : PH_HBAD;
      end else if (pos_r >= 8'd187) begin
        pos_nxt = 8'd188;
      end else begin
        pos_nxt = pos;
        if (pos < 8'd4) begin
          if (ph_r == PH_HDR || ph_r == PH_HBAD) begin
            if (pos == 8'd1) begin
              held_nxt = cell_byte;
              if (cell_byte[7]) ph_nxt = PH_HBAD;
            end
            if (pos == 8'd3) begin
              if (ph_r == PH_HBAD || (cell_byte & 8'hC0) != 8'd0) begin
                res_valid = 1'b1; res.kind = K_BAD_CELL;
                insndu_nxt = 1'b0; len_nxt = '0; type_nxt = '0; thalf_nxt = 1'b0;
                left_nxt = '0; dbit_nxt = 1'b0;
                await_nxt = 1'b1; ph_nxt = PH_IDLE;
              end else if (!await_r && cell_byte[3:0] == ecc_r) begin
                ecc_nxt = ecc_r + 4'd1;
                if (held_r[6]) ph_nxt = PH_PTRC;
                else if (insndu_r) ph_nxt = PH_DATA;
                else ph_nxt = thalf_r ? PH_TYPE1 : PH_TYPE0;
              end else begin
                if (!await_r) begin
                  res_valid = 1'b1; res.kind = K_DISCONT;
                  insndu_nxt = 1'b0; len_nxt = '0; type_nxt = '0; thalf_nxt = 1'b0;
                  left_nxt = '0; dbit_nxt = 1'b0; await_nxt = 1'b1;
                end
                if (held_r[6]) begin
                  ecc_nxt = cell_byte[3:0] + 4'd1;
                  ph_nxt = PH_PTRS;
                end else ph_nxt = PH_IDLE;
              end
            end
          end
        end else begin
          case (ph_r)
            PH_PTRS: begin
              if (cell_byte > 8'd184) begin
                ph_nxt = PH_IDLE; res_valid = 1'b1; res.kind = K_BAD_PTR;
              end else if (cell_byte >= 8'd182) begin
                len_nxt = '0; await_nxt = 1'b1; ph_nxt = PH_IDLE;
                res_valid = 1'b1; res.kind = K_SHORT;
              end else begin
                await_nxt = 1'b0; ptr_nxt = cell_byte;
                ph_nxt = (cell_byte != 8'd0) ? PH_SKIP : PH_LEN0;
              end
            end
            PH_PTRC: begin
              if (cell_byte >= 8'd183 || {8'd0, cell_byte} != left_r) begin
                res_valid = 1'b1; res.kind = K_BAD_PTR;
                insndu_nxt = 1'b0; len_nxt = '0; type_nxt = '0; thalf_nxt = 1'b0;
                left_nxt = '0; dbit_nxt = 1'b0; await_nxt = 1'b1; ph_nxt = PH_IDLE;
              end else if (insndu_r) ph_nxt = PH_DATA;
              else ph_nxt = thalf_r ? PH_TYPE1 : PH_TYPE0;
            end
            PH_SKIP: begin
              if (ptr_r <= 8'd1) begin
                ptr_nxt = 8'd0; ph_nxt = PH_LEN0;
              end else ptr_nxt = ptr_r - 8'd1;
            end
            PH_LEN0, PH_NEXT0: begin
              held_nxt = cell_byte;
              crc_nxt = crc_feed(32'hFFFFFFFF, cell_byte);
              ph_nxt = (ph_r == PH_LEN0) ? PH_LEN1 : PH_NEXT1;
            end
            PH_LEN1, PH_NEXT1: begin
              if (ph_r == PH_NEXT1 && held_r == 8'hFF && cell_byte == 8'hFF) begin
                ph_nxt = PH_IDLE;
              end else begin
                dbit_nxt = v[15];
                crc_nxt = crc_feed(crc_r, cell_byte);
                if (v[14:0] < 15'd5) begin
                  len_nxt = '0; await_nxt = 1'b1; ph_nxt = PH_IDLE;
                  res_valid = 1'b1; res.kind = K_BAD_LEN; res.dest_absent = v[15];
                end else begin
                  len_nxt = v[14:0];
                  left_nxt = {1'b0, v[14:0]} + 16'd2;
                  ph_nxt = PH_TYPE0;
                end
              end
            end
            PH_TYPE0: begin
              type_nxt = {cell_byte, 8'd0}; thalf_nxt = 1'b1;
              left_nxt = left_r - 16'd1;
              crc_nxt = crc_feed(crc_r, cell_byte); ph_nxt = PH_TYPE1;
            end
            PH_TYPE1: begin
              type_nxt = type_r | {8'd0, cell_byte}; thalf_nxt = 1'b0;
              insndu_nxt = 1'b1; left_nxt = {1'b0, len_r};
              crc_nxt = crc_feed(crc_r, cell_byte); crx_nxt = '0; ph_nxt = PH_DATA;
            end
            PH_DATA: begin
              if (left_r > 16'd4) begin
                crc_nxt = crc_feed(crc_r, cell_byte);
                left_nxt = left_r - 16'd1;
                res_valid = 1'b1; res.out_byte = cell_byte;
              end else begin
                crx_nxt = {crx_r[23:0], cell_byte};
                if (left_r > 16'd1) left_nxt = left_r - 16'd1;
                else begin
                  res_valid = 1'b1; res.last = 1'b1;
                  res.kind = (crc_r == {crx_r[23:0], cell_byte}) ? K_OK : K_CRC_FAIL;
                  insndu_nxt = 1'b0; len_nxt = '0; type_nxt = '0; thalf_nxt = 1'b0;
                  left_nxt = '0; dbit_nxt = 1'b0;
                  ph_nxt = (pos <= 8'd185) ? PH_NEXT0 : PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b1; ecc_r <= '0; pos_r <= '0; ph_r <= PH_IDLE; insndu_r <= 1'b0;
      len_r <= '0; left_r <= '0; type_r <= '0; thalf_r <= 1'b0; dbit_r <= 1'b0;
      ptr_r <= '0; held_r <= '0; crc_r <= '1; crx_r <= '0;
    end else begin
      await_r <= await_nxt; ecc_r <= ecc_nxt; pos_r <= pos_nxt; ph_r <= ph_nxt;
      insndu_r <= insndu_nxt; len_r <= len_nxt; left_r <= left_nxt; type_r <= type_nxt;
      thalf_r <= thalf_nxt; dbit_r <= dbit_nxt; ptr_r <= ptr_nxt; held_r <= held_nxt;
      crc_r <= crc_nxt; crx_r <= crx_nxt;
    end
  end

endmodule

/* hdl/tsr_queue.sv */
// ----------------------------------------------------------------------------
// tsr_queue: result queue
// Small register queue between the parser and the result port.
// ----------------------------------------------------------------------------
module tsr_queue import tsr_pkg::*; #(
  parameter int unsigned DEPTH = QDepth
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  result_t wdata,
  input  logic    rd,
  output result_t rdata,
  output logic    empty,
  output logic    full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  result_t        mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

/* hdl/ts_cell_to_sndu_reassembler_core.sv */
// ----------------------------------------------------------------------------
// ts_cell_to_sndu_reassembler_core: ULE SNDU reassembly from TS cells
// Parser front end feeding a result queue towards the consumer.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: push one TS byte per request with in_cell_start high on the
//    sync byte of each 188-byte cell. Accepted when push && !full.
//  - Output: queue-style. While empty is low the oldest result sits on the
//    out_ ports; pop takes it. Each byte yields zero or one result.
//  - Throughput: one byte per cycle while full is low; the parser handles a
//    byte in the cycle it is accepted (CRC byte update is a combinational
//    XOR network); each result is registered into the queue on acceptance.
//  - Stall: a QDepth-entry queue holds results; full rises when it could
//    not absorb another result, so input stalls only when the consumer lags.
//  - Reset (rst_n low, synchronous): parser waits for a unit start, queue
//    is emptied, CRC accumulator set to all ones.
// ----------------------------------------------------------------------------
module ts_cell_to_sndu_reassembler_core import tsr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_cell_byte,
  input  logic        in_cell_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_out_byte,
  output logic [3:0]  out_kind,
  output logic [15:0] out_sndu_type,
  output logic        out_dest_absent,
  output logic        out_last
);

  logic    step, res_valid, q_full;
  result_t res, head;

  // accept only while the queue has room for one more result
  assign full = q_full;
  assign step = push && !q_full;

  tsr_parser u_parser (
    .clk, .rst_n, .step, .cell_byte(in_cell_byte), .cell_start(in_cell_start),
    .res_valid, .res
  );

  tsr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr(res_valid), .wdata(res), .rd(pop && !empty),
    .rdata(head), .empty, .full(q_full)
  );

  assign out_out_byte    = head.out_byte;
  assign out_kind        = head.kind;
  assign out_sndu_type   = head.sndu_type;
  assign out_dest_absent = head.dest_absent;
  assign out_last        = head.last;

endmodule

/* test/ts_cell_to_sndu_reassembler_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_cell_to_sndu_reassembler_core_tb: self-checking bench for SNDU reassembly
// Feeds TS cells byte by byte. The bytes come from a short directed table and
// then from a random ULE packer with injected cell, pointer and CRC faults.
// Each popped result is checked against an in-bench parser model or typed row.
// ----------------------------------------------------------------------------
module ts_cell_to_sndu_reassembler_core_tb;
  import tsr_pkg::*;

  // parser phases of the bench model
  typedef enum logic [3:0] {
    P_IDLE, P_HDR, P_HBAD, P_PTRS, P_PTRC, P_SKIP, P_LEN0, P_LEN1,
    P_NEXT0, P_NEXT1, P_TYPE0, P_TYPE1, P_DATA
  } phase_t;

  typedef struct {
    logic [7:0] b;
    logic       st;
    logic       chk;   // typed expectation on this row
    kind_t      k;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_cell_byte = 8'd0;
  logic        in_cell_start = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_out_byte;
  logic [3:0]  out_kind;
  logic [15:0] out_sndu_type;
  logic        out_dest_absent;
  logic        out_last;

  always #5 clk = ~clk;

  ts_cell_to_sndu_reassembler_core DUT (
    .clk, .rst_n, .push, .full, .in_cell_byte, .in_cell_start,
    .empty, .pop, .out_out_byte, .out_kind, .out_sndu_type,
    .out_dest_absent, .out_last
  );

  // -------------------------------------------------------------------------
  // Parser model state
  // -------------------------------------------------------------------------
  logic        wait_pusi;
  logic [3:0]  next_cc;
  logic [7:0]  pos_in_cell;
  phase_t      phase;
  logic        body_open;
  logic [14:0] len_field;
  logic [15:0] remain;
  logic [15:0] type_acc;
  logic        type_hi_done;
  logic        dbit;
  logic [7:0]  ptr_cnt;
  logic [7:0]  hdr_b1;
  logic [31:0] crc_run;
  logic [31:0] crc_got;

  result_t     sndu_results_q[$];   // results still due from the block
  int          errors = 0;
  int          kind_seen[9];
  int          cells_sent = 0;
  int          sndus_built = 0;
  int          sent_cnt = 0;
  bit          hold_done = 1'b0;

  // MPEG-2 CRC-32, bit-serial, MSB first
  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ d[i];
      c  = {c[30:0], 1'b0};
      if (fb) c = c ^ 32'h04C11DB7;
    end
    return c;
  endfunction

  function automatic result_t mk_res(logic [7:0] b, kind_t k, logic lst);
    result_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.sndu_type   = type_acc;
    r.dest_absent = dbit;
    r.last        = lst;
    return r;
  endfunction

  task automatic drop_sndu();
    body_open    = 1'b0;
    len_field    = '0;
    type_acc     = '0;
    type_hi_done = 1'b0;
    remain       = '0;
    dbit         = 1'b0;
  endtask

  task automatic parser_reset();
    drop_sndu();
    wait_pusi   = 1'b1;
    next_cc     = '0;
    pos_in_cell = '0;
    phase       = P_IDLE;
    ptr_cnt     = '0;
    hdr_b1      = '0;
    crc_run     = '1;
    crc_got     = '0;
  endtask

  function automatic phase_t resume_at();
    if (body_open) return P_DATA;
    return type_hi_done ? P_TYPE1 : P_TYPE0;
  endfunction

  // Advance the model by one accepted byte; hit is set when a result is due.
  task automatic parse_byte(input logic [7:0] b, input logic st,
                            output logic hit, output result_t r);
    int unsigned left;
    logic [15:0] v;
    hit = 1'b0;
    r   = '0;
    if (st) begin
      if (!body_open && len_field == 0) wait_pusi = 1'b1;
      pos_in_cell = '0;
      phase = (b == 8'h47) ? P_HDR : P_HBAD;
      return;
    end
    if (pos_in_cell >= 187) begin   // long cell, trailing bytes ignored
      pos_in_cell = 188;
      return;
    end
    pos_in_cell++;
    left = 187 - pos_in_cell;

    if (pos_in_cell < 4) begin
      if (phase != P_HDR && phase != P_HBAD) return;
      if (pos_in_cell == 1) begin
        hdr_b1 = b;
        if (b[7]) phase = P_HBAD;
      end
      if (pos_in_cell != 3) return;
      if (phase == P_HBAD || b[7:6] != 2'b00) begin
        hit = 1'b1; r = mk_res(8'd0, K_BAD_CELL, 1'b0);
        drop_sndu();
        wait_pusi = 1'b1;
        phase = P_IDLE;
        return;
      end
      if (!wait_pusi) begin
        if (b[3:0] == next_cc) begin
          next_cc++;
          phase = hdr_b1[6] ? P_PTRC : resume_at();
          return;
        end
        hit = 1'b1; r = mk_res(8'd0, K_DISCONT, 1'b0);
        drop_sndu();
        wait_pusi = 1'b1;
      end
      // discontinuity with unit start falls through to resync
      if (hdr_b1[6]) begin
        next_cc = b[3:0] + 4'd1;
        phase = P_PTRS;
      end else begin
        phase = P_IDLE;
      end
      return;
    end

    case (phase)
      P_PTRS: begin
        if (b > 184) begin
          phase = P_IDLE;
          hit = 1'b1; r = mk_res(8'd0, K_BAD_PTR, 1'b0);
        end else if (b >= 182) begin   // header would not fit
          len_field = '0;
          wait_pusi = 1'b1;
          phase = P_IDLE;
          hit = 1'b1; r = mk_res(8'd0, K_SHORT, 1'b0);
        end else begin
          wait_pusi = 1'b0;
          ptr_cnt = b;
          phase = (b != 0) ? P_SKIP : P_LEN0;
        end
      end
      P_PTRC: begin
        if (b >= 183 || {8'd0, b} != remain) begin
          hit = 1'b1; r = mk_res(8'd0, K_BAD_PTR, 1'b0);
          drop_sndu();
          wait_pusi = 1'b1;
          phase = P_IDLE;
        end else begin
          phase = resume_at();
        end
      end
      P_SKIP: begin
        if (ptr_cnt <= 1) begin
          ptr_cnt = '0;
          phase = P_LEN0;
        end else begin
          ptr_cnt--;
        end
      end
      P_LEN0, P_NEXT0: begin
        hdr_b1 = b;
        crc_run = crc32_step(32'hFFFF_FFFF, b);
        phase = (phase == P_LEN0) ? P_LEN1 : P_NEXT1;
      end
      P_LEN1, P_NEXT1: begin
        if (phase == P_NEXT1 && hdr_b1 == 8'hFF && b == 8'hFF) begin   // padding
          phase = P_IDLE;
          return;
        end
        v = {hdr_b1, b};
        dbit = v[15];
        crc_run = crc32_step(crc_run, b);
        if (v[14:0] < 5) begin
          len_field = '0;
          wait_pusi = 1'b1;
          phase = P_IDLE;
          hit = 1'b1; r = mk_res(8'd0, K_BAD_LEN, 1'b0);
        end else begin
          len_field = v[14:0];
          remain = {1'b0, v[14:0]} + 16'd2;
          phase = P_TYPE0;
        end
      end
      P_TYPE0: begin
        type_acc = {b, 8'd0};
        type_hi_done = 1'b1;
        remain--;
        crc_run = crc32_step(crc_run, b);
        phase = P_TYPE1;
      end
      P_TYPE1: begin
        type_acc[7:0] = b;
        type_hi_done = 1'b0;
        body_open = 1'b1;
        remain = {1'b0, len_field};
        crc_run = crc32_step(crc_run, b);
        crc_got = '0;
        phase = P_DATA;
      end
      P_DATA: begin
        if (remain > 4) begin
          crc_run = crc32_step(crc_run, b);
          remain--;
          hit = 1'b1; r = mk_res(b, K_PAYLOAD, 1'b0);
        end else begin
          crc_got = {crc_got[23:0], b};
          if (remain > 1) begin
            remain--;
          end else begin
            hit = 1'b1;
            r = mk_res(8'd0, (crc_run == crc_got) ? K_OK : K_CRC_FAIL, 1'b1);
            drop_sndu();
            phase = (left >= 2) ? P_NEXT0 : P_IDLE;
          end
        end
      end
      default: ;
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps
  // -------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] b, input logic st,
                           input logic typed, input kind_t tk);
    int gap;
    logic hit;
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push          <= 1'b1;
    in_cell_byte  <= b;
    in_cell_start <= st;
    do @(posedge clk); while (full);
    burst_left--;
    sent_cnt++;
    parse_byte(b, st, hit, r);
    if (typed) begin
      r = '0;
      r.kind = tk;
      sndu_results_q.push_back(r);
    end else if (hit) begin
      sndu_results_q.push_back(r);
    end
  endtask

  // -------------------------------------------------------------------------
  // Random ULE packer
  // -------------------------------------------------------------------------
  logic [7:0] sndu_q[$];   // unsent remainder of the SNDU in progress
  logic [3:0] gen_cc = '0;

  task automatic build_sndu();
    logic [7:0]  tmp[$];
    int          plen;
    logic [14:0] len;
    logic        d;
    logic [15:0] ty;
    logic [31:0] c;
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 40);
    len  = 15'(plen + 4);
    d    = $urandom_range(0, 1);
    ty   = ($urandom_range(0, 1) != 0) ? 16'h0800 : 16'($urandom);
    tmp.push_back({d, len[14:8]});
    tmp.push_back(len[7:0]);
    tmp.push_back(ty[15:8]);
    tmp.push_back(ty[7:0]);
    repeat (plen) tmp.push_back(8'($urandom));
    c = '1;
    foreach (tmp[i]) c = crc32_step(c, tmp[i]);
    for (int i = 3; i >= 0; i--) tmp.push_back(c[8*i +: 8]);
    if ($urandom_range(0, 7) == 0) tmp[tmp.size()-1] ^= 8'(1 << $urandom_range(0, 7));
    sndu_q = {sndu_q, tmp};
    sndus_built++;
  endtask

  task automatic send_cell();
    logic [7:0] c[$];
    int rem, space, take, k;
    logic pusi;
    rem  = sndu_q.size();
    pusi = (rem <= 181);
    c.push_back(8'h47);
    c.push_back({1'b0, pusi, 1'b0, 5'($urandom)});
    c.push_back(8'($urandom));
    c.push_back({2'b00, 2'($urandom), gen_cc});
    gen_cc++;
    if (pusi) c.push_back(8'(rem));
    space = pusi ? 183 : 184;
    take = (rem < space) ? rem : space;
    repeat (take) c.push_back(sndu_q.pop_front());
    space -= take;
    while (space > 0) begin
      if (pusi && space >= 2 && $urandom_range(0, 7) != 0) begin
        build_sndu();
        take = (sndu_q.size() < space) ? sndu_q.size() : space;
        repeat (take) c.push_back(sndu_q.pop_front());
        space -= take;
      end else begin
        repeat (space) c.push_back(8'hFF);   // stuffing
        space = 0;
      end
    end
    // occasional faults on the cell
    case ($urandom_range(0, 15))
      0: c[1][7] = 1'b1;                                  // transport error
      1: c[0] = 8'($urandom_range(0, 70));                // lost sync
      2: c[3][3:0] = 4'($urandom);                        // continuity slip
      3: c[3][7:6] = 2'($urandom_range(1, 3));            // scrambled
      4: begin                                            // short cell
        k = $urandom_range(1, 187);
        c = c[0:k-1];
      end
      5: repeat ($urandom_range(1, 5)) c.push_back(8'($urandom));   // long cell
      6: c[$urandom_range(4, 187)] = 8'($urandom);        // payload hit
      7: if (pusi) c[4] = 8'($urandom);                   // odd pointer
      default: ;
    endcase
    foreach (c[i]) send_byte(c[i], i == 0, 1'b0, K_PAYLOAD);
    cells_sent++;
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  dir_row_t dir_tab[25];
  int rand_start;

  initial begin
    dir_tab = '{
      // transport error bit set
      '{8'h47, 1, 0, K_PAYLOAD}, '{8'h80, 0, 0, K_PAYLOAD}, '{8'h00, 0, 0, K_PAYLOAD},
      '{8'h10, 0, 1, K_BAD_CELL},
      // sync byte missing
      '{8'h00, 1, 0, K_PAYLOAD}, '{8'h00, 0, 0, K_PAYLOAD}, '{8'h00, 0, 0, K_PAYLOAD},
      '{8'h10, 0, 1, K_BAD_CELL},
      // pointer past the payload
      '{8'h47, 1, 0, K_PAYLOAD}, '{8'h40, 0, 0, K_PAYLOAD}, '{8'h00, 0, 0, K_PAYLOAD},
      '{8'h10, 0, 0, K_PAYLOAD}, '{8'hFF, 0, 1, K_BAD_PTR},
      // pointer leaves no room for a header
      '{8'h47, 1, 0, K_PAYLOAD}, '{8'h40, 0, 0, K_PAYLOAD}, '{8'h00, 0, 0, K_PAYLOAD},
      '{8'h11, 0, 0, K_PAYLOAD}, '{8'd183, 0, 1, K_SHORT},
      // length under the minimum
      '{8'h47, 1, 0, K_PAYLOAD}, '{8'h5F, 0, 0, K_PAYLOAD}, '{8'hFF, 0, 0, K_PAYLOAD},
      '{8'h12, 0, 0, K_PAYLOAD}, '{8'h00, 0, 0, K_PAYLOAD}, '{8'h00, 0, 0, K_PAYLOAD},
      '{8'h02, 0, 1, K_BAD_LEN}
    };
    foreach (kind_seen[i]) kind_seen[i] = 0;
    parser_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].st, dir_tab[i].chk, dir_tab[i].k);

    rand_start = sent_cnt;
    while (sent_cnt - rand_start < 800) send_cell();
    push <= 1'b0;

    while (sndu_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d cells carrying %0d SNDUs", sent_cnt, cells_sent,
             sndus_built);
    $display("Results: payload %0d ok %0d crc %0d cell %0d discont %0d ptr %0d len %0d short %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6], kind_seen[8]);
    if (errors == 0 && sndu_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: pops on its own pattern, one long hold-off to fill the queue
  // -------------------------------------------------------------------------
  initial begin : receiver
    int      mode;
    int      win;
    int      hold_cnt;
    result_t e;
    mode = 0;
    win = 0;
    hold_cnt = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (sndu_results_q.size() == 0) begin
          $error("result with none expected: kind %0d byte %0h", out_kind, out_out_byte);
          errors++;
        end else begin
          e = sndu_results_q.pop_front();
          if (out_out_byte !== e.out_byte) begin
            $error("out_byte: expected %0h, got %0h", e.out_byte, out_out_byte); errors++;
          end
          if (out_kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_kind); errors++;
          end
          if (out_sndu_type !== e.sndu_type) begin
            $error("sndu_type: expected %0h, got %0h", e.sndu_type, out_sndu_type); errors++;
          end
          if (out_dest_absent !== e.dest_absent) begin
            $error("dest_absent: expected %0b, got %0b", e.dest_absent, out_dest_absent);
            errors++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_last); errors++;
          end
          if (out_kind < 9) kind_seen[out_kind]++;
        end
      end
      // long stall once the random traffic is flowing
      if (!hold_done && sent_cnt >= 300) begin
        hold_done = 1'b1;
        hold_cnt = 250;
      end
      if (win == 0) begin
        win = $urandom_range(8, 64);
        mode = $urandom_range(0, 3);
      end
      win--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= $urandom_range(0, 1);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
